// ===== sv/smm_pkg.sv =====
// Shared types, constants and codes of the segmented memory manager.
package smm_pkg;

    localparam int MaxSegments = 256;
    localparam int SlotWords   = 1024;
    localparam int IdW         = $clog2(MaxSegments);
    localparam int OffW        = $clog2(SlotWords);
    localparam int LenW        = OffW + 1;
    localparam int AddrW       = IdW + OffW;
    localparam int CntW        = IdW + 1;
    localparam int QDepth      = 2;

    typedef enum logic [2:0] {
        OP_MAP    = 3'd0,
        OP_UNMAP  = 3'd1,
        OP_LOAD   = 3'd2,
        OP_STORE  = 3'd3,
        OP_DUP    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_ID      = 3'd1,
        ST_UNMAPPED   = 3'd2,
        ST_OFFSET     = 3'd3,
        ST_UNMAP_ZERO = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  seg_id;
        logic [9:0]  word_offset;
        logic [31:0] store_value;
        logic [10:0] segment_length;
    } t_req;

    typedef struct packed {
        logic [31:0] result_word;
        logic [2:0]  status;
    } t_rsp;

    // Command from the classifier to the memory engine.
    typedef enum logic [2:0] {
        K_REPLY = 3'd0,   // nothing to do in memory
        K_READ  = 3'd1,
        K_WRITE = 3'd2,
        K_FILL  = 3'd3,   // zero-fill count words of a slot
        K_COPY  = 3'd4    // copy count words of a slot into slot zero
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IdW-1:0]   id;
        logic [OffW-1:0]  off;
        logic [31:0]      value;
        logic [LenW-1:0]  count;
        t_rsp             rsp;
    } t_cmd;

endpackage

// ===== sv/segmented_memory_manager_core.sv =====
// Top level of the segmented memory manager: classifier, command queue, memory engine.
// A request passes the classifier, the command queue and the memory engine before its result is registered.
// Map zero-fills the new slot word by word; duplicate reads and writes each word in turn into slot zero (one port).
// The classifier takes no new request while it classifies the previous one; a load also holds the engine for its read.
// Reset is synchronous and active low; segment zero is mapped and empty afterwards.
// Word store contents are undefined after reset until mapped, so no clearing pass.
module segmented_memory_manager_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  smm_pkg::t_req i_req,
    input  logic          push,
    output logic          full,
    output smm_pkg::t_rsp o_rsp,
    output logic          empty,
    input  logic          pop
);
    smm_pkg::t_cmd w_fcmd;
    logic          w_fvalid;
    logic          w_qfull;
    smm_pkg::t_cmd w_qcmd;
    logic          w_qempty;
    logic          w_qpop;

    smm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_push      (push),
        .o_full      (full),
        .o_cmd       (w_fcmd),
        .o_cmd_valid (w_fvalid),
        .i_cmd_full  (w_qfull)
    );

    smm_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_fcmd),
        .i_push  (w_fvalid),
        .o_full  (w_qfull),
        .o_cmd   (w_qcmd),
        .o_empty (w_qempty),
        .i_pop   (w_qpop)
    );

    smm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_qcmd),
        .i_cmd_empty (w_qempty),
        .o_cmd_pop   (w_qpop),
        .o_rsp       (o_rsp),
        .o_empty     (empty),
        .i_pop       (pop)
    );
endmodule

// ===== sv/smm_front.sv =====
// Request classifier: identifier pool, length table and mapped flags.
module smm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smm_pkg::t_req  i_req,
    input  logic           i_push,
    output logic           o_full,
    output smm_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_full
);
    logic [smm_pkg::LenW-1:0] r_len [smm_pkg::MaxSegments];
    logic [smm_pkg::MaxSegments-1:0] r_mapped;
    logic [smm_pkg::IdW-1:0] r_fifo [smm_pkg::MaxSegments];
    logic [smm_pkg::IdW-1:0] r_head;
    logic [smm_pkg::CntW-1:0] r_free_cnt;
    logic [smm_pkg::CntW-1:0] r_fresh;

    // The length table is not reset; an entry reads as zero until set since reset.
    logic [smm_pkg::MaxSegments-1:0] r_len_ok;

    // A beat is taken in one cycle and classified in the next, once the tables have been read.
    logic                     r_busy;
    smm_pkg::t_req            r_req;
    logic [smm_pkg::LenW-1:0] r_len_rd;
    logic [smm_pkg::IdW-1:0]  r_fifo_rd;

    logic                     w_acc;
    smm_pkg::t_op             w_op;
    logic [smm_pkg::IdW-1:0]  w_id;
    logic [smm_pkg::LenW-1:0] w_len_id;
    logic [smm_pkg::LenW-1:0] w_map_len;
    logic [smm_pkg::IdW-1:0]  w_nid;
    logic                     w_has_id;
    logic [smm_pkg::IdW-1:0]  w_tail;
    smm_pkg::t_cmd            n_cmd;

    assign o_full      = r_busy || i_cmd_full;
    assign w_acc       = i_push && !o_full;
    assign w_op        = smm_pkg::t_op'(r_req.opcode);
    assign w_id        = r_req.seg_id[smm_pkg::IdW-1:0];
    assign w_len_id    = r_len_ok[w_id] ? r_len_rd : '0;
    assign w_map_len   = (r_req.segment_length > smm_pkg::LenW'(smm_pkg::SlotWords))
                         ? smm_pkg::LenW'(smm_pkg::SlotWords) : r_req.segment_length;
    assign w_has_id    = (r_free_cnt != '0) ||
                         (r_fresh < smm_pkg::CntW'(smm_pkg::MaxSegments));
    assign w_nid       = (r_free_cnt != '0) ? r_fifo_rd : r_fresh[smm_pkg::IdW-1:0];
    assign w_tail      = r_head + r_free_cnt[smm_pkg::IdW-1:0];

    always_comb begin
        n_cmd       = '0;
        n_cmd.kind  = smm_pkg::K_REPLY;
        n_cmd.id    = w_id;
        n_cmd.off   = r_req.word_offset;
        n_cmd.value = r_req.store_value;
        n_cmd.rsp.status = smm_pkg::ST_OK;
        case (w_op)
            smm_pkg::OP_MAP: begin
                if (!w_has_id) begin
                    n_cmd.rsp.status = smm_pkg::ST_NO_ID;
                end else begin
                    n_cmd.kind  = smm_pkg::K_FILL;
                    n_cmd.id    = w_nid;
                    n_cmd.count = w_map_len;
                    n_cmd.rsp.result_word = 32'(w_nid);
                end
            end
            smm_pkg::OP_UNMAP: begin
                if (w_id == '0) begin
                    n_cmd.rsp.status = smm_pkg::ST_UNMAP_ZERO;
                end else if (!r_mapped[w_id]) begin
                    n_cmd.rsp.status = smm_pkg::ST_UNMAPPED;
                end
            end
            smm_pkg::OP_LOAD, smm_pkg::OP_STORE: begin
                if (!r_mapped[w_id]) begin
                    n_cmd.rsp.status = smm_pkg::ST_UNMAPPED;
                end else if (smm_pkg::LenW'(r_req.word_offset) >= w_len_id) begin
                    n_cmd.rsp.status = smm_pkg::ST_OFFSET;
                end else begin
                    n_cmd.kind = (w_op == smm_pkg::OP_LOAD) ? smm_pkg::K_READ
                                                            : smm_pkg::K_WRITE;
                end
            end
            smm_pkg::OP_DUP: begin
                if (w_id != '0) begin
                    if (!r_mapped[w_id]) begin
                        n_cmd.rsp.status = smm_pkg::ST_UNMAPPED;
                    end else begin
                        n_cmd.kind  = smm_pkg::K_COPY;
                        n_cmd.count = w_len_id;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped    <= smm_pkg::MaxSegments'(1);
            r_len_ok    <= '0;
            r_head      <= '0;
            r_free_cnt  <= '0;
            r_fresh     <= smm_pkg::CntW'(1);
            r_busy      <= 1'b0;
            o_cmd_valid <= 1'b0;
        end else begin
            r_busy      <= w_acc;
            o_cmd_valid <= r_busy;
            if (r_busy) begin
                case (w_op)
                    smm_pkg::OP_MAP: begin
                        if (w_has_id) begin
                            if (r_free_cnt != '0) begin
                                r_head     <= r_head + 1'b1;
                                r_free_cnt <= r_free_cnt - 1'b1;
                            end else begin
                                r_fresh <= r_fresh + 1'b1;
                            end
                            r_mapped[w_nid] <= 1'b1;
                            r_len_ok[w_nid] <= 1'b1;
                            r_len[w_nid]    <= w_map_len;
                        end
                    end
                    smm_pkg::OP_UNMAP: begin
                        if (w_id != '0 && r_mapped[w_id]) begin
                            r_mapped[w_id] <= 1'b0;
                            r_len_ok[w_id] <= 1'b1;
                            r_len[w_id]    <= '0;
                            r_fifo[w_tail] <= w_id;
                            r_free_cnt     <= r_free_cnt + 1'b1;
                        end
                    end
                    smm_pkg::OP_DUP: begin
                        if (w_id != '0 && r_mapped[w_id]) begin
                            r_len_ok[0] <= 1'b1;
                            r_len[0]    <= w_len_id;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req     <= i_req;
            r_len_rd  <= r_len[i_req.seg_id[smm_pkg::IdW-1:0]];
            r_fifo_rd <= r_fifo[r_head];
        end
        o_cmd <= n_cmd;
    end
endmodule

// ===== sv/smm_cmd_queue.sv =====
// Short command queue between the classifier and the memory engine.
module smm_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  smm_pkg::t_cmd i_cmd,
    input  logic          i_push,
    output logic          o_full,
    output smm_pkg::t_cmd o_cmd,
    output logic          o_empty,
    input  logic          i_pop
);
    localparam int PtrW = $clog2(smm_pkg::QDepth);

    smm_pkg::t_cmd   r_mem [smm_pkg::QDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [PtrW:0]   r_cnt;
    logic            w_wr;
    logic            w_rd;

    // One slot is held back for the command still in the classifier register.
    assign o_full  = (r_cnt >= (PtrW+1)'(smm_pkg::QDepth - 1));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_wr    = i_push;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW+1)'(w_wr) - (PtrW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

// ===== sv/smm_back.sv =====
// Memory engine: word store accesses, zero-fill and copy sweeps, result register.
module smm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  smm_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output smm_pkg::t_rsp o_rsp,
    output logic          o_empty,
    input  logic          i_pop
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_FILL, S_COPY_RD, S_COPY_WR, S_DONE
    } t_state;

    logic [31:0] r_store [2**smm_pkg::AddrW];

    t_state                   r_state;
    smm_pkg::t_cmd            r_cmd;
    logic [smm_pkg::LenW-1:0] r_idx;
    logic [31:0]              r_rdata;
    logic                     r_out_valid;
    smm_pkg::t_rsp            r_out;

    logic                      w_we;
    logic [smm_pkg::AddrW-1:0] w_waddr;
    logic [31:0]               w_wdata;
    logic                      w_re;
    logic [smm_pkg::AddrW-1:0] w_raddr;
    logic                      w_take;
    logic                      w_free;

    assign o_rsp   = r_out;
    assign o_empty = !r_out_valid;
    assign w_free  = !r_out_valid || i_pop;
    assign w_take  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_cmd_pop = w_take;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_cmd.id, r_idx[smm_pkg::OffW-1:0]};
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = {r_cmd.id, r_idx[smm_pkg::OffW-1:0]};
        case (r_state)
            S_IDLE: begin
                if (w_take && i_cmd.kind == smm_pkg::K_WRITE) begin
                    w_we    = 1'b1;
                    w_waddr = {i_cmd.id, i_cmd.off};
                    w_wdata = i_cmd.value;
                end
                if (w_take && i_cmd.kind == smm_pkg::K_READ) begin
                    w_re    = 1'b1;
                    w_raddr = {i_cmd.id, i_cmd.off};
                end
            end
            S_FILL: begin
                w_we = (r_idx < r_cmd.count);
            end
            S_COPY_RD: begin
                w_re = (r_idx < r_cmd.count);
            end
            S_COPY_WR: begin
                w_we    = 1'b1;
                w_waddr = {smm_pkg::IdW'(0), r_idx[smm_pkg::OffW-1:0]};
                w_wdata = r_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_store[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_pop && r_out_valid && !(r_state == S_DONE && w_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        case (i_cmd.kind)
                            smm_pkg::K_READ:  r_state <= S_READ;
                            smm_pkg::K_FILL:  r_state <= S_FILL;
                            smm_pkg::K_COPY:  r_state <= S_COPY_RD;
                            default:          r_state <= S_DONE;
                        endcase
                    end
                end
                S_READ: begin
                    r_cmd.rsp.result_word <= r_rdata;
                    r_state <= S_DONE;
                end
                S_FILL: begin
                    if (r_idx < r_cmd.count) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_COPY_RD: begin
                    r_state <= (r_idx < r_cmd.count) ? S_COPY_WR : S_DONE;
                end
                S_COPY_WR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_COPY_RD;
                end
                S_DONE: begin
                    if (w_free) begin
                        r_out       <= r_cmd.rsp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/smm_checker.sv =====
// Port-level checker for the segmented memory manager, bound to the top level.
module smm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          push,
    input logic          full,
    input smm_pkg::t_rsp o_rsp,
    input logic          empty,
    input logic          pop
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rsp)))
        else $error("result changed while waiting");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_rsp.status <= smm_pkg::ST_UNMAP_ZERO))
        else $error("status out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rsp.status != smm_pkg::ST_OK) |-> (o_rsp.result_word == '0))
        else $error("error result carries data");

    // The classifier reports full after every beat it takes, while it classifies that beat.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("input accepted on consecutive cycles");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
endmodule

bind segmented_memory_manager_core smm_checker u_smm_checker (.*);
